### hw/rtl/frame_rate_preset_tracker_defines.svh
// Assertion macros used by the checker file of the preset tracker.
`ifndef FRAME_RATE_PRESET_TRACKER_DEFINES_SVH
`define FRAME_RATE_PRESET_TRACKER_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define FRPT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define FRPT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/frpt_pkg.sv
`default_nettype none

package frpt_pkg;

  localparam int unsigned TABLE_LEN      = 12;
  localparam int unsigned NUM_PRESETS    = 12;
  localparam int unsigned ACTIVE_PRESETS =
    (NUM_PRESETS < TABLE_LEN) ? NUM_PRESETS : TABLE_LEN;
  localparam int unsigned RATE_FRAC_BITS = 4;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned FPS_W     = 9;
  localparam int unsigned RATE_W    = 19;
  localparam int unsigned FIX_W     = 18;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned EVID_W    = 14;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam int unsigned TOP_LIMIT_FPS  = 10000;
  localparam int unsigned MIN_MARGIN_FPS = 6;
  localparam int unsigned FIRST_ELAPSED  = 250;
  localparam int unsigned MIN_ELAPSED    = 100;
  localparam int unsigned MAX_ELAPSED    = 1000;
  localparam logic [EVID_W-1:0] CONFIRM_RESET = 14'd10000;

  // Register index, taken from paddr[2].
  localparam logic REG_CONFIRM_MS = 1'b0;

  localparam logic [FPS_W-1:0] PRESET_FPS [TABLE_LEN] = '{
    9'd30, 9'd60, 9'd90, 9'd120, 9'd144, 9'd165,
    9'd180, 9'd200, 9'd240, 9'd300, 9'd360, 9'd480
  };

  typedef struct packed {
    logic [ACTIVE_PRESETS-1:0] win;
    logic [ACTIVE_PRESETS-1:0] gt;
    logic [ACTIVE_PRESETS-1:0] lt;
    logic [IDX_W-1:0]          near;
    logic [ELAPSED_W-1:0]      elapsed;
  } frpt_item_t;

  function automatic logic [FPS_W-1:0] fps_of(input logic [IDX_W-1:0] idx);
    logic [FPS_W-1:0] r;
    r = PRESET_FPS[0];
    if (idx < IDX_W'(ACTIVE_PRESETS)) begin
      r = PRESET_FPS[idx];
    end
    return r;
  endfunction

  function automatic logic [31:0] fixed_of(input logic [31:0] fps);
    return fps << RATE_FRAC_BITS;
  endfunction

  // Inclusive acceptance window of preset i. The upper bound beyond the minimum
  // margin is gap/3 above the preset, compared exactly after scaling by three.
  function automatic logic win_hit(input logic [FIX_W-1:0] f, input int unsigned i);
    logic [31:0] fx;
    logic [31:0] lower;
    logic [31:0] p;
    logic [31:0] gap;
    logic        hit;
    fx    = 32'(f);
    lower = '0;
    p     = 32'(PRESET_FPS[i]);
    gap   = '0;
    hit   = 1'b0;
    if (i > 0) begin
      lower = fixed_of(32'(PRESET_FPS[i-1]) + 32'd1);
    end
    if (i + 1 == ACTIVE_PRESETS) begin
      hit = (fx >= lower) && (fx <= fixed_of(32'(TOP_LIMIT_FPS)));
    end else begin
      gap = 32'(PRESET_FPS[i+1]) - p;
      hit = (fx >= lower) &&
            ((fx <= fixed_of(p + 32'(MIN_MARGIN_FPS))) ||
             ((fx * 32'd3) <= fixed_of(p * 32'd3 + gap)));
    end
    return hit;
  endfunction

  // True when f lies strictly above the midpoint of presets i and i+1.
  function automatic logic above_mid(input logic [FIX_W-1:0] f, input int unsigned i);
    return (32'(f) << 1) > fixed_of(32'(PRESET_FPS[i]) + 32'(PRESET_FPS[i+1]));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/frpt_if.sv
`default_nettype none

interface frpt_in_if #(
  parameter int unsigned TIME_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic signed [18:0]    rate_sample;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, output rate_sample, output time_ms, input ready);
  modport sink (input valid, input rate_sample, input time_ms, output ready);
endinterface

interface frpt_out_if;
  logic       valid;
  logic       ready;
  logic       switched;
  logic [3:0] preset_index;
  logic [8:0] preset_rate;

  modport source (output valid, output switched, output preset_index,
                  output preset_rate, input ready);
  modport sink (input valid, input switched, input preset_index,
                input preset_rate, output ready);
endinterface

`default_nettype wire

### hw/rtl/frpt_front.sv
`default_nettype none

module frpt_front #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  frpt_in_if.sink                sample,
  input  wire logic              push_ready,
  output logic                   push_valid,
  output frpt_pkg::frpt_item_t   push_data
);
  import frpt_pkg::*;

  logic                       have_last;
  logic [TIME_BITS-1:0]       last_time;
  logic [FIX_W-1:0]           f;
  logic [TIME_BITS-1:0]       delta;
  logic [ACTIVE_PRESETS-1:0]  mid;
  logic [ACTIVE_PRESETS-1:0]  below;
  logic [ACTIVE_PRESETS-1:0]  sel;
  logic                       accept;
  logic [ELAPSED_W-1:0]       elapsed;
  logic [ACTIVE_PRESETS-1:0]  win;
  logic [ACTIVE_PRESETS-1:0]  gt;
  logic [ACTIVE_PRESETS-1:0]  lt;
  logic [IDX_W-1:0]           near;

  assign sample.ready = push_ready;
  assign push_valid   = sample.valid;
  assign accept       = sample.valid && push_ready;
  assign push_data    = {win, gt, lt, near, elapsed};

  // Negative rates count as zero.
  assign f     = sample.rate_sample[RATE_W-1] ? '0 : sample.rate_sample[FIX_W-1:0];
  assign delta = sample.time_ms - last_time;

  always_comb begin
    if (!have_last) begin
      elapsed = ELAPSED_W'(FIRST_ELAPSED);
    end else if (sample.time_ms <= last_time) begin
      elapsed = ELAPSED_W'(MIN_ELAPSED);
    end else if (delta < TIME_BITS'(MIN_ELAPSED)) begin
      elapsed = ELAPSED_W'(MIN_ELAPSED);
    end else if (delta > TIME_BITS'(MAX_ELAPSED)) begin
      elapsed = ELAPSED_W'(MAX_ELAPSED);
    end else begin
      elapsed = delta[ELAPSED_W-1:0];
    end
  end

  // Window hits and position against every preset, all in parallel.
  always_comb begin
    mid = '0;
    for (int unsigned i = 0; i < ACTIVE_PRESETS; i++) begin
      win[i] = win_hit(f, i);
      gt[i]  = 32'(f) > fixed_of(32'(PRESET_FPS[i]));
      lt[i]  = 32'(f) < fixed_of(32'(PRESET_FPS[i]));
    end
    for (int unsigned i = 0; i + 1 < ACTIVE_PRESETS; i++) begin
      mid[i] = above_mid(f, i);
    end
  end

  // The midpoint compares form a thermometer code; its edge is the nearest
  // preset, and an exact tie stays with the lower one.
  assign below = {mid[ACTIVE_PRESETS-2:0], 1'b1};
  assign sel   = below & ~mid;

  always_comb begin
    near = '0;
    for (int unsigned k = 0; k < ACTIVE_PRESETS; k++) begin
      near = near | (sel[k] ? IDX_W'(k) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      last_time <= '0;
    end else if (accept) begin
      have_last <= 1'b1;
      last_time <= sample.time_ms;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frpt_queue.sv
`default_nettype none

module frpt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  frpt_pkg::frpt_item_t   push_data,
  output logic                   push_ready,
  output logic                   pop_valid,
  output frpt_pkg::frpt_item_t   pop_data,
  input  wire logic              pop_ready
);
  import frpt_pkg::*;

  frpt_item_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frpt_back.sv
`default_nettype none

module frpt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [13:0]       confirm_ms,
  input  wire logic              pop_valid,
  input  frpt_pkg::frpt_item_t   pop_data,
  output logic                   pop_ready,
  frpt_out_if.source             result
);
  import frpt_pkg::*;

  logic              have_cur, have_cur_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic              have_cand, have_cand_next;
  logic [IDX_W-1:0]  cand, cand_next;
  logic [EVID_W-1:0] evid, evid_next;
  logic              sw_next;
  logic              out_valid;
  logic              out_sw;
  logic [IDX_W-1:0]  out_idx;
  logic [FPS_W-1:0]  out_rate;
  logic              take;

  assign pop_ready = !out_valid || result.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    logic [EVID_W:0]      ev_sum;
    logic [ELAPSED_W:0]   loss;
    logic [IDX_W-1:0]     nx;
    have_cur_next  = have_cur;
    cur_next       = cur;
    have_cand_next = have_cand;
    cand_next      = cand;
    evid_next      = evid;
    sw_next        = 1'b0;
    ev_sum         = (EVID_W+1)'(evid) + (EVID_W+1)'(pop_data.elapsed);
    loss           = {pop_data.elapsed, 1'b0};
    nx             = pop_data.near;
    if (!have_cur) begin
      have_cur_next = 1'b1;
      cur_next      = pop_data.near;
    end else begin
      if (have_cand) begin
        if (pop_data.win[cand]) begin
          evid_next = (ev_sum < (EVID_W+1)'(confirm_ms)) ? ev_sum[EVID_W-1:0] : confirm_ms;
        end else begin
          evid_next = (evid > EVID_W'(loss)) ? evid - EVID_W'(loss) : '0;
          if (evid <= EVID_W'(loss)) begin
            have_cand_next = 1'b0;
          end
        end
      end
      // Propose a neighbor when the nearest preset is the current one.
      if (pop_data.near == cur) begin
        if (pop_data.gt[cur] && cur != IDX_W'(ACTIVE_PRESETS - 1)) begin
          nx = cur + IDX_W'(1);
        end else if (pop_data.lt[cur] && cur != '0) begin
          nx = cur - IDX_W'(1);
        end
      end
      if (!have_cand_next && !pop_data.win[cur] && nx != cur && pop_data.win[nx]) begin
        have_cand_next = 1'b1;
        cand_next      = nx;
        evid_next      = EVID_W'(pop_data.elapsed);
      end
      if (have_cand_next && evid_next >= confirm_ms) begin
        cur_next       = cand_next;
        have_cand_next = 1'b0;
        cand_next      = '0;
        evid_next      = '0;
        sw_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_cur  <= 1'b0;
      cur       <= '0;
      have_cand <= 1'b0;
      cand      <= '0;
      evid      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        have_cur  <= have_cur_next;
        cur       <= cur_next;
        have_cand <= have_cand_next;
        cand      <= cand_next;
        evid      <= evid_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_sw   <= sw_next;
      out_idx  <= cur_next;
      out_rate <= fps_of(cur_next);
    end
  end

  assign result.valid        = out_valid;
  assign result.switched     = out_sw;
  assign result.preset_index = out_idx;
  assign result.preset_rate  = out_rate;

endmodule

`default_nettype wire

### hw/rtl/frame_rate_preset_tracker.sv
`default_nettype none
// An accepted sample is written into the queue; its result beat is held in the back's output register.
// Throughput: one sample per cycle while result.ready holds; the front classifies against all
// presets in parallel and the back updates tracker state for each item it takes.
// A two-entry queue and the output register let the input run while a result waits.
// Reset (rst, synchronous, active high) clears tracker state and sets confirm_ms to 10000.

module frame_rate_preset_tracker #(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  frpt_in_if.sink          sample,
  frpt_out_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import frpt_pkg::*;

  logic [EVID_W-1:0] confirm_ms;
  logic              push_valid;
  logic              push_ready;
  frpt_item_t        push_data;
  logic              pop_valid;
  logic              pop_ready;
  frpt_item_t        pop_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_ms <= CONFIRM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CONFIRM_MS) begin
      confirm_ms <= pwdata[EVID_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CONFIRM_MS) begin
      prdata = DATA_W'(confirm_ms);
    end
  end

  frpt_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  frpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  frpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .confirm_ms (confirm_ms),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

### hw/rtl/frpt_checker.sv
`default_nettype none
`include "frame_rate_preset_tracker_defines.svh"

module frpt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic        switched,
  input wire logic [3:0]  preset_index,
  input wire logic [8:0]  preset_rate,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);
  import frpt_pkg::*;

  `FRPT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !result_valid, "result valid after reset")

  `FRPT_ASSERT(a_result_hold, clk, rst,
    (result_valid && !result_ready) |=> (result_valid && $stable(switched) &&
      $stable(preset_index) && $stable(preset_rate)), "stalled result beat changed")

  `FRPT_ASSERT(a_rate_matches, clk, rst,
    result_valid |-> (preset_rate == fps_of(preset_index) &&
      preset_index < 4'(ACTIVE_PRESETS)), "preset rate does not match index")

  `FRPT_ASSERT(a_cfg_readback, clk, rst,
    (psel && penable && pwrite && paddr[2] == REG_CONFIRM_MS) |=>
      ((paddr[2] != REG_CONFIRM_MS) || (prdata == {18'b0, $past(pwdata[13:0])})),
    "confirm_ms readback mismatch")

endmodule

bind frame_rate_preset_tracker frpt_checker u_frpt_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .switched     (result.switched),
  .preset_index (result.preset_index),
  .preset_rate  (result.preset_rate),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

`default_nettype wire

### tb/sv/frame_rate_preset_tracker_checker.sv
module frame_rate_preset_tracker_checker
  import frpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  frpt_in_if          smp,
  frpt_out_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          sample_count,
  output int          result_count,
  output int          switch_count
);

  localparam int unsigned PRESETS = ACTIVE_PRESETS;
  localparam int unsigned FRAC    = RATE_FRAC_BITS;

  typedef struct packed {
    logic       sw;
    logic [3:0] idx;
    logic [8:0] fps;
  } preset_result_t;

  preset_result_t expected_presets[$];

  // Tracker state as the block should hold it.
  logic [EVID_W-1:0] confirm;
  logic              has_current;
  int unsigned       cur_idx;
  logic              has_cand;
  int unsigned       cand_idx;
  int unsigned       evid;
  logic              seen_time;
  logic [47:0]       last_t;

  function automatic logic rate_in_window(input int unsigned i, input int unsigned f);
    int unsigned lower;
    int unsigned p;
    int unsigned gap;
    logic        hit;
    hit   = 1'b0;
    lower = 0;
    if (i < PRESETS) begin
      if (i > 0) begin
        lower = (int'(PRESET_FPS[i-1]) + 1) << FRAC;
      end
      if (f >= lower) begin
        if (i + 1 == PRESETS) begin
          hit = f <= (TOP_LIMIT_FPS << FRAC);
        end else begin
          p   = PRESET_FPS[i];
          gap = int'(PRESET_FPS[i+1]) - p;
          // The gap/3 margin is compared after scaling both sides by three.
          hit = (f <= ((p + MIN_MARGIN_FPS) << FRAC)) ||
                (3 * f <= ((3 * p + gap) << FRAC));
        end
      end
    end
    return hit;
  endfunction

  function automatic int unsigned nearest_preset(input int unsigned f);
    int unsigned best;
    int unsigned best_dist;
    int unsigned d;
    int unsigned p;
    best      = 0;
    p         = int'(PRESET_FPS[0]) << FRAC;
    best_dist = (f > p) ? f - p : p - f;
    for (int unsigned i = 1; i < PRESETS; i++) begin
      p = int'(PRESET_FPS[i]) << FRAC;
      d = (f > p) ? f - p : p - f;
      if (d < best_dist) begin
        best      = i;
        best_dist = d;
      end
    end
    return best;
  endfunction

  // When the sample is still nearest the current preset, step one preset
  // toward it instead.
  function automatic int unsigned neighbor_preset(input int unsigned f, input int unsigned cur);
    int unsigned c;
    int unsigned p;
    c = nearest_preset(f);
    if (c == cur) begin
      p = int'(PRESET_FPS[cur]) << FRAC;
      if (f > p && cur + 1 < PRESETS) begin
        c = cur + 1;
      end else if (f < p && cur > 0) begin
        c = cur - 1;
      end
    end
    return c;
  endfunction

  function automatic preset_result_t track_sample(input logic [18:0] raw,
                                                  input logic [47:0] t);
    int unsigned    f;
    int unsigned    elapsed;
    int unsigned    loss;
    int unsigned    nx;
    logic [47:0]    d;
    preset_result_t r;
    f    = raw[18] ? 0 : int'(raw[17:0]);
    r.sw = 1'b0;
    if (!seen_time) begin
      elapsed = FIRST_ELAPSED;
    end else if (t <= last_t) begin
      elapsed = MIN_ELAPSED;
    end else begin
      d = t - last_t;
      if (d < 48'(MIN_ELAPSED)) begin
        elapsed = MIN_ELAPSED;
      end else if (d > 48'(MAX_ELAPSED)) begin
        elapsed = MAX_ELAPSED;
      end else begin
        elapsed = int'(d[9:0]);
      end
    end
    seen_time = 1'b1;
    last_t    = t;

    if (!has_current) begin
      has_current = 1'b1;
      cur_idx     = nearest_preset(f);
    end else begin
      if (has_cand) begin
        if (rate_in_window(cand_idx, f)) begin
          evid = (evid + elapsed < confirm) ? evid + elapsed : confirm;
        end else begin
          loss = 2 * elapsed;
          evid = (evid > loss) ? evid - loss : 0;
          if (evid == 0) begin
            has_cand = 1'b0;
          end
        end
      end
      if (!has_cand && !rate_in_window(cur_idx, f)) begin
        nx = neighbor_preset(f, cur_idx);
        if (nx != cur_idx && rate_in_window(nx, f)) begin
          has_cand = 1'b1;
          cand_idx = nx;
          evid     = elapsed;
        end
      end
      if (has_cand && evid >= confirm) begin
        cur_idx  = cand_idx;
        has_cand = 1'b0;
        cand_idx = 0;
        evid     = 0;
        r.sw     = 1'b1;
      end
    end
    if (cur_idx >= PRESETS) begin
      cur_idx = 0;
    end
    r.idx = 4'(cur_idx);
    r.fps = PRESET_FPS[cur_idx];
    return r;
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    sample_count = 0;
    result_count = 0;
    switch_count = 0;
  end

  always @(posedge clk) begin
    preset_result_t got;
    preset_result_t want;
    if (rst) begin
      confirm     = CONFIRM_RESET;
      has_current = 1'b0;
      cur_idx     = 0;
      has_cand    = 1'b0;
      cand_idx    = 0;
      evid        = 0;
      seen_time   = 1'b0;
      last_t      = '0;
      expected_presets.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_CONFIRM_MS) begin
        if (pwrite) begin
          confirm = pwdata[EVID_W-1:0];
        end else if (prdata !== 32'(confirm)) begin
          $error("confirm_ms readback: expected %0d, got %0d", confirm, prdata);
          fail_count++;
        end
      end
      // Results are matched before new samples, so a result beat cannot pair
      // with a sample accepted at the same edge.
      if (res.valid && res.ready) begin
        got.sw  = res.switched;
        got.idx = res.preset_index;
        got.fps = res.preset_rate;
        result_count++;
        if (expected_presets.size() == 0) begin
          $error("result beat with no sample outstanding");
          fail_count++;
        end else begin
          want = expected_presets.pop_front();
          if (want.sw) begin
            switch_count++;
          end
          if (got.sw !== want.sw) begin
            $error("switched: expected %0d, got %0d", want.sw, got.sw);
            fail_count++;
          end
          if (got.idx !== want.idx) begin
            $error("preset_index: expected %0d, got %0d", want.idx, got.idx);
            fail_count++;
          end
          if (got.fps !== want.fps) begin
            $error("preset_rate: expected %0d, got %0d", want.fps, got.fps);
            fail_count++;
          end
        end
      end
      if (smp.valid && smp.ready) begin
        expected_presets.push_back(track_sample(smp.rate_sample, smp.time_ms));
        sample_count++;
      end
    end
    pending = expected_presets.size();
  end

endmodule

### tb/sv/frame_rate_preset_tracker_tb.sv
module frame_rate_preset_tracker_tb;
  import frpt_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_ITEMS   = 125;
  localparam logic [2:0] CONFIRM_ADDR  = {REG_CONFIRM_MS, 2'b00};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          sample_count;
  int          result_count;
  int          switch_count;
  int          config_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic [47:0] clock_ms = '0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_tick = 0;

  frpt_in_if #(.TIME_BITS(48)) smp ();
  frpt_out_if res ();

  frame_rate_preset_tracker u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_rate_preset_tracker_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp),
    .res          (res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .sample_count (sample_count),
    .result_count (result_count),
    .switch_count (switch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: runs of always-ready, random stalls and a fixed stall rhythm.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= ($urandom_range(0, 9) < 7);
      default: res.ready <= (rx_tick % 9) >= 4;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one sample beat; bursts of beats are separated by random gaps.
  task automatic send_sample(input logic [18:0] rate, input logic [47:0] t);
    if (burst_left == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    smp.valid       <= 1'b1;
    smp.rate_sample <= rate;
    smp.time_ms     <= t;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // psel is left high so a write can be followed directly by a read.
  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= wr;
    paddr  <= CONFIRM_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
  endtask

  // Writes confirm_ms once every outstanding result has come back, then reads it.
  task automatic set_confirm(input logic [13:0] ms);
    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    apb_access(1'b1, 32'(ms));
    apb_access(1'b0, '0);
    psel <= 1'b0;
    config_count++;
  endtask

  initial begin
    int         k;
    int         len;
    int         sel;
    int         lo;
    int         hi;
    int         p;
    int         gap;
    int         rate;
    int         n;
    logic [13:0] cfg;

    rst             = 1'b1;
    smp.valid       = 1'b0;
    smp.rate_sample = '0;
    smp.time_ms     = '0;
    res.ready       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First sample sits exactly between 30 and 60 fps and must pick 30.
    send_sample(19'd720, 48'd0);
    send_sample(19'h40000, 48'd0);
    send_sample(19'h3FFFF, 48'd5);
    send_sample(19'd7680, 48'd100000);
    send_sample(19'd7680, 48'd101000);
    send_sample(19'd7680, 48'd102000);
    // Confirmation time dropped below the evidence already collected.
    set_confirm(14'd2000);
    send_sample(19'd7680, 48'd102500);
    set_confirm(14'd0);
    send_sample(19'd960, 48'd103000);
    set_confirm(14'h3FFF);
    send_sample(19'd1136, 48'd104000);
    send_sample(19'd1136, 48'hFFFF_FFFF_FFFF);
    send_sample(19'd960, 48'd0);
    set_confirm(14'd1);
    send_sample(19'd3413, 48'd200);
    send_sample(19'd3413, 48'd1200);
    send_sample(19'd3414, 48'd2200);
    send_sample(19'd2416, 48'd3200);
    send_sample(19'd2417, 48'd4200);
    send_sample(19'd160000, 48'd5200);
    send_sample(19'd160001, 48'd6200);
    send_sample(19'd640, 48'd7200);
    send_sample(19'd640, 48'd8200);
    send_sample(19'd641, 48'd9200);
    clock_ms = 48'd9200;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: cfg = CONFIRM_RESET;
        1: cfg = 14'h3FFF;
        2: cfg = 14'd1;
        3: cfg = 14'd0;
        4: cfg = 14'($urandom_range(100, 3000));
        default: cfg = 14'($urandom_range(1, 16383));
      endcase
      set_confirm(cfg);
      n = 0;
      while (n < PHASE_ITEMS) begin
        // A run of samples around one preset, with some stray and edge values.
        k   = $urandom_range(0, ACTIVE_PRESETS - 1);
        len = $urandom_range(3, 40);
        p   = PRESET_FPS[k];
        lo  = (k == 0) ? 0 : (int'(PRESET_FPS[(k == 0) ? 0 : k - 1]) + 1) << RATE_FRAC_BITS;
        if (k == ACTIVE_PRESETS - 1) begin
          hi = TOP_LIMIT_FPS << RATE_FRAC_BITS;
        end else begin
          gap = int'(PRESET_FPS[k + 1]) - p;
          hi  = ((3 * p + gap) << RATE_FRAC_BITS) / 3;
          if (hi < ((p + MIN_MARGIN_FPS) << RATE_FRAC_BITS)) begin
            hi = (p + MIN_MARGIN_FPS) << RATE_FRAC_BITS;
          end
        end
        for (int j = 0; j < len && n < PHASE_ITEMS; j++) begin
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            rate = (p << RATE_FRAC_BITS) + $urandom_range(0, 192) - 96;
          end else if (sel < 80) begin
            case ($urandom_range(0, 3))
              0: rate = lo - 1;
              1: rate = lo;
              2: rate = hi;
              default: rate = hi + 1;
            endcase
          end else if (sel < 90) begin
            rate = $urandom_range(0, 19'h7FFFF);
          end else begin
            rate = $urandom_range(0, 500 << RATE_FRAC_BITS);
          end
          sel = $urandom_range(0, 99);
          if (sel < 80) begin
            clock_ms += 48'($urandom_range(100, 1200));
          end else if (sel < 88) begin
            clock_ms += 48'($urandom_range(0, 99));
          end else if (sel < 94) begin
            clock_ms -= 48'($urandom_range(0, 3000));
          end else if (sel < 98) begin
            clock_ms += 48'($urandom_range(1001, 1000000));
          end else begin
            clock_ms = 48'({$urandom, $urandom});
          end
          send_sample(19'(rate), clock_ms);
          n++;
        end
      end
    end

    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d rate samples, checked %0d result beats, %0d of them preset switches.",
             sample_count, result_count, switch_count);
    $display("confirm_ms took %0d settings, including 0, 1, 16383 and the reset value.",
             config_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
